@@ src/first_seen_index_renumbering_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dense renumbering table
// Concurrent property checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_SEEN_INDEX_RENUMBERING_MACROS_SVH
`define FIRST_SEEN_INDEX_RENUMBERING_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define FSIR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fsir assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define FSIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fsir assertion failed");

`else

`define FSIR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FSIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/fsir_pkg.sv @@
// ----------------------------------------------------------------------------
// Dense renumbering table package
// Sizes, command codes and controller states shared by the design files.
// ----------------------------------------------------------------------------
package fsir_pkg;

    // Number of table entries; the address width follows from it.
    localparam int ENTRIES = 1024;
    localparam int ADDR_W  = $clog2(ENTRIES);

    // Fixed field widths of the item and result ports.
    localparam int CMD_W   = 2;
    localparam int CODE_W  = 10;
    localparam int COUNT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_RENUMBER = 2'd0,
        CMD_REVERSE  = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FWD   = 2'd1,
        ST_CHECK = 2'd2,
        ST_REV   = 2'd3
    } t_state;

endpackage

@@ src/fsir_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module fsir_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/first_seen_index_renumbering.sv @@
// ----------------------------------------------------------------------------
// Dense renumbering table
// Maps sparse internal indices onto dense codes in order of first appearance.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// -------   ---------  -----------------------------  -------------------------
// item      in         start high while busy is low   i_cmd, i_index_in
// result    out        o_valid strobe, one cycle      o_code_out, o_is_new,
//                                                     o_code_count, o_out_of_range
//
// A renumber item reads the forward table, then the reverse table at the
// code found there, and then the block decides and writes. A reverse-read
// item makes one reverse-table read. Clear, the unused command and a
// renumber of an index beyond the table are answered without a table read.
// The result strobe rises in the cycle after the last of those steps, and
// busy is already low then, so the next item may be accepted alongside it.
// Reset is synchronous and active low and leaves the table empty at once;
// the receiver cannot stall, so every result is shown exactly once.
//
// The forward and reverse tables hold no valid bits. An index counts as
// seen when its forward entry names a code below the count and the reverse
// entry of that code points back at the index. A clear therefore only has
// to zero the count, and stale entries from before the clear can never pass
// that test.
// ----------------------------------------------------------------------------
`include "first_seen_index_renumbering_macros.svh"

module first_seen_index_renumbering
    import fsir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [CODE_W-1:0]  i_index_in,
    output logic               o_valid,
    output logic [CODE_W-1:0]  o_code_out,
    output logic               o_is_new,
    output logic [COUNT_W-1:0] o_code_count,
    output logic               o_out_of_range
);

    localparam logic [COUNT_W-1:0] ENTRIES_C = COUNT_W'(ENTRIES);

    // Controller state and latched item.
    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [CODE_W-1:0]    r_index, n_index;
    logic [CODE_W-1:0]    r_fwd_code, n_fwd_code;
    logic [COUNT_W-1:0]   r_count, n_count;

    // Result register.
    logic                 r_valid, n_valid;
    logic [CODE_W-1:0]    r_code_out, n_code_out;
    logic                 r_is_new, n_is_new;
    logic [COUNT_W-1:0]   r_code_count, n_code_count;
    logic                 r_oor, n_oor;

    // Table ports.
    logic [ADDR_W-1:0]    fwd_addr, rev_addr;
    logic                 fwd_we, rev_we;
    logic [CODE_W-1:0]    fwd_wdata, rev_wdata;
    logic [CODE_W-1:0]    fwd_rdata, rev_rdata;

    logic                 accept;
    logic                 hit;

    assign accept = start && (r_state == ST_IDLE);

    // Forward table: index to code.
    fsir_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ENTRIES)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_addr  (fwd_addr),
        .i_we    (fwd_we),
        .i_wdata (fwd_wdata),
        .o_rdata (fwd_rdata)
    );

    // Reverse table: code to index.
    fsir_ram #(
        .WIDTH (CODE_W),
        .DEPTH (ENTRIES)
    ) u_rev_ram (
        .i_clk   (i_clk),
        .i_addr  (rev_addr),
        .i_we    (rev_we),
        .i_wdata (rev_wdata),
        .o_rdata (rev_rdata)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_RENUMBER: begin
                            if ({1'b0, i_index_in} < ENTRIES_C) begin
                                n_state = ST_FWD;
                            end
                        end
                        CMD_REVERSE: n_state = ST_REV;
                        CMD_CLEAR:   n_state = ST_IDLE;
                        CMD_NOP:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FWD:   n_state = ST_CHECK;
            ST_CHECK: n_state = ST_IDLE;
            ST_REV:   n_state = ST_IDLE;
        endcase
    end

    // The entry is known when its code lies below the count and the reverse
    // table points back at this index.
    assign hit = ({1'b0, r_fwd_code} < r_count) && (rev_rdata == r_index);

    // Datapath, table accesses and result.
    always_comb begin
        n_cmd        = r_cmd;
        n_index      = r_index;
        n_fwd_code   = r_fwd_code;
        n_count      = r_count;
        n_valid      = 1'b0;
        n_code_out   = '0;
        n_is_new     = 1'b0;
        n_oor        = 1'b0;
        n_code_count = r_count;
        fwd_addr     = r_index[ADDR_W-1:0];
        rev_addr     = r_fwd_code[ADDR_W-1:0];
        fwd_we       = 1'b0;
        rev_we       = 1'b0;
        fwd_wdata    = r_count[CODE_W-1:0];
        rev_wdata    = r_index;

        unique case (r_state)
            ST_IDLE: begin
                fwd_addr = i_index_in[ADDR_W-1:0];
                rev_addr = i_index_in[ADDR_W-1:0];
                if (accept) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_index = i_index_in;
                    unique case (t_cmd'(i_cmd))
                        CMD_RENUMBER: begin
                            // An index beyond the table is refused at once.
                            if ({1'b0, i_index_in} >= ENTRIES_C) begin
                                n_valid = 1'b1;
                                n_oor   = 1'b1;
                            end
                        end
                        CMD_REVERSE: begin
                        end
                        CMD_CLEAR: begin
                            n_count      = '0;
                            n_code_count = '0;
                            n_valid      = 1'b1;
                        end
                        CMD_NOP: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_FWD: begin
                // Follow the forward entry into the reverse table.
                rev_addr   = fwd_rdata[ADDR_W-1:0];
                n_fwd_code = fwd_rdata;
            end
            ST_CHECK: begin
                n_valid  = 1'b1;
                rev_addr = r_count[ADDR_W-1:0];
                if (hit) begin
                    n_code_out = r_fwd_code;
                end else if (r_count >= ENTRIES_C) begin
                    n_oor = 1'b1;
                end else begin
                    fwd_we       = 1'b1;
                    rev_we       = 1'b1;
                    n_count      = r_count + COUNT_W'(1);
                    n_code_count = r_count + COUNT_W'(1);
                    n_code_out   = r_count[CODE_W-1:0];
                    n_is_new     = 1'b1;
                end
            end
            ST_REV: begin
                n_valid = 1'b1;
                if ({1'b0, r_index} >= r_count || {1'b0, r_index} >= ENTRIES_C) begin
                    n_oor = 1'b1;
                end else begin
                    n_code_out = rev_rdata;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_index      <= n_index;
        r_fwd_code   <= n_fwd_code;
        r_code_out   <= n_code_out;
        r_is_new     <= n_is_new;
        r_code_count <= n_code_count;
        r_oor        <= n_oor;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_code_out     = r_code_out;
    assign o_is_new       = r_is_new;
    assign o_code_count   = r_code_count;
    assign o_out_of_range = r_oor;

    // A clear is answered in the next cycle with an empty table.
    `FSIR_ASSERT_NEXT(a_clear_result, i_clk, i_rst_n,
        accept && (i_cmd == CMD_CLEAR), o_valid && (o_code_count == '0))

    // A fresh code is always the last one handed out.
    `FSIR_ASSERT_SAME(a_new_code_last, i_clk, i_rst_n,
        o_valid && o_is_new, ({1'b0, o_code_out} + COUNT_W'(1)) == o_code_count)

    // A fresh code is never flagged as refused.
    `FSIR_ASSERT_SAME(a_new_not_refused, i_clk, i_rst_n,
        o_valid && o_is_new, !o_out_of_range)

    // A renumber lookup always runs to its decision cycle.
    `FSIR_ASSERT_NEXT(a_lookup_chain, i_clk, i_rst_n,
        r_state == ST_FWD, (r_state == ST_CHECK) && (r_cmd == CMD_RENUMBER))

endmodule
